// ----- rtl/core/h264au_pkg.sv -----
// ----------------------------------------------------------------------------
// h264au_pkg
// types, constants and helpers for the annex b access unit splitter
// ----------------------------------------------------------------------------
package h264au_pkg;

   localparam int MaxItems = 6;
   localparam int CountWidth = $clog2(MaxItems + 1);

   localparam logic [7:0] ByteZero = 8'h00;
   localparam logic [7:0] ByteOne = 8'h01;
   localparam logic [7:0] TypeMask = 8'h1F;
   localparam logic [4:0] TypeSliceIdr = 5'd5;
   localparam logic [4:0] TypeSliceLow = 5'd1;
   localparam logic [4:0] TypeSps = 5'd7;
   localparam logic [4:0] TypePps = 5'd8;
   localparam logic [1:0] MaxHeld = 2'd3;

   localparam logic [1:0] KindParams = 2'd0;
   localparam logic [1:0] KindSlice = 2'd1;
   localparam logic [1:0] KindIdr = 2'd2;

   typedef enum logic [1:0] {
      PhSeek = 2'd0,
      PhHeader = 2'd1,
      PhCopy = 2'd2,
      PhDrop = 2'd3
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       buffer_last;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       group_end;
      logic [1:0] group_kind;
      logic       run_last;
   } rsp_type;

   typedef rsp_type [MaxItems-1:0] list_type;

   function automatic list_type push_item(list_type l, logic [CountWidth-1:0] n, rsp_type it);
      list_type r;
      r = l;
      if (n < CountWidth'(MaxItems)) begin
         r[n[$clog2(MaxItems)-1:0]] = it;
      end
      return r;
   endfunction

   function automatic logic [CountWidth-1:0] bump_count(logic [CountWidth-1:0] n);
      logic [CountWidth-1:0] r;
      r = n;
      if (n < CountWidth'(MaxItems)) begin
         r = n + CountWidth'(1);
      end
      return r;
   endfunction

   function automatic rsp_type byte_item(logic [7:0] b);
      rsp_type r;
      r = '0;
      r.out_byte = b;
      return r;
   endfunction

   function automatic rsp_type marker_item(logic has_slice, logic has_idr);
      rsp_type r;
      r = '0;
      r.group_end = 1'b1;
      r.group_kind = has_idr ? KindIdr : (has_slice ? KindSlice : KindParams);
      return r;
   endfunction

endpackage

// ----- rtl/core/h264_annexb_access_unit_splitter.sv -----
// ----------------------------------------------------------------------------
// h264_annexb_access_unit_splitter
// reframes an annex b byte stream into parameter and slice groups
// ----------------------------------------------------------------------------
// the result items of an accepted request are registered and presented from the cycle after it
// throughput: one request per cycle while each request yields at most one
//   item and the result side does not stall; a request yielding more items
//   holds off the next one until the last item of its result list is taken,
//   the list being drained one item per cycle while the result side does not stall
// reset: synchronous, clears parse state and group flags, empties the result list
// ----------------------------------------------------------------------------
module h264_annexb_access_unit_splitter (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  h264au_pkg::req_type  req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output h264au_pkg::rsp_type  rsp_payload
);

   localparam int CW = h264au_pkg::CountWidth;

   h264au_pkg::phase_type phase_ff, phase_in;
   logic [1:0]            held_ff, held_in;
   logic                  gp_ff, gp_in, gs_ff, gs_in, gi_ff, gi_in;
   h264au_pkg::list_type  list_ff, list_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic [CW-1:0]         rd_ff;

   logic                  req_take, rsp_take, drained;
   logic [7:0]            b;
   logic [4:0]            nal_type;
   logic                  keep;

   assign rsp_valid   = rd_ff != cnt_ff;
   assign rsp_payload = list_ff[rd_ff[$clog2(h264au_pkg::MaxItems)-1:0]];
   assign rsp_take    = rsp_valid && !rsp_stall;
   assign drained     = !rsp_valid || (rsp_take && (rd_ff + CW'(1) == cnt_ff));
   assign req_stall   = !drained;
   assign req_take    = req_valid && drained;

   always_comb begin
      phase_in = phase_ff;
      held_in  = held_ff;
      gp_in    = gp_ff;
      gs_in    = gs_ff;
      gi_in    = gi_ff;
      list_in  = '0;
      cnt_in   = '0;
      keep     = 1'b0;
      b        = req_payload.data_byte;
      nal_type = 5'(b & h264au_pkg::TypeMask);

      // owed marker
      if (phase_in == h264au_pkg::PhSeek) begin
         if (gp_in || gs_in) begin
            list_in = h264au_pkg::push_item(list_in, cnt_in,
                                            h264au_pkg::marker_item(gs_in, gi_in));
            cnt_in  = h264au_pkg::bump_count(cnt_in);
         end
         gp_in = 1'b0;
         gs_in = 1'b0;
         gi_in = 1'b0;
      end

      if (phase_in == h264au_pkg::PhHeader) begin
         if (b == h264au_pkg::ByteZero) begin
            if (held_in < h264au_pkg::MaxHeld) begin
               held_in = held_in + 2'd1;
            end else begin
               if (gp_in || gs_in) begin
                  list_in = h264au_pkg::push_item(list_in, cnt_in,
                                                  h264au_pkg::marker_item(gs_in, gi_in));
                  cnt_in  = h264au_pkg::bump_count(cnt_in);
               end
               gp_in = 1'b0;
               gs_in = 1'b0;
               gi_in = 1'b0;
               phase_in = h264au_pkg::PhDrop;
            end
         end else if (b == h264au_pkg::ByteOne && held_in >= 2'd2) begin
            held_in = 2'd0;
         end else if (held_in >= 2'd1) begin
            if (gp_in || gs_in) begin
               list_in = h264au_pkg::push_item(list_in, cnt_in,
                                               h264au_pkg::marker_item(gs_in, gi_in));
               cnt_in  = h264au_pkg::bump_count(cnt_in);
            end
            gp_in = 1'b0;
            gs_in = 1'b0;
            gi_in = 1'b0;
            phase_in = h264au_pkg::PhDrop;
            held_in = 2'd0;
         end else begin
            if (nal_type == h264au_pkg::TypeSps || nal_type == h264au_pkg::TypePps) begin
               if (gs_in) begin
                  list_in = h264au_pkg::push_item(list_in, cnt_in,
                                                  h264au_pkg::marker_item(gs_in, gi_in));
                  cnt_in  = h264au_pkg::bump_count(cnt_in);
                  gp_in = 1'b0;
                  gs_in = 1'b0;
                  gi_in = 1'b0;
               end
               gp_in = 1'b1;
               keep  = 1'b1;
            end else if (nal_type inside {[h264au_pkg::TypeSliceLow:h264au_pkg::TypeSliceIdr]})
            begin
               gs_in = 1'b1;
               if (nal_type == h264au_pkg::TypeSliceIdr) begin
                  gi_in = 1'b1;
               end
               keep = 1'b1;
            end else begin
               if (gp_in || gs_in) begin
                  list_in = h264au_pkg::push_item(list_in, cnt_in,
                                                  h264au_pkg::marker_item(gs_in, gi_in));
                  cnt_in  = h264au_pkg::bump_count(cnt_in);
               end
               gp_in = 1'b0;
               gs_in = 1'b0;
               gi_in = 1'b0;
               phase_in = h264au_pkg::PhDrop;
            end
            if (keep) begin
               for (int i = 0; i < 3; i++) begin
                  list_in = h264au_pkg::push_item(list_in, cnt_in,
                                                  h264au_pkg::byte_item(h264au_pkg::ByteZero));
                  cnt_in  = h264au_pkg::bump_count(cnt_in);
               end
               list_in = h264au_pkg::push_item(list_in, cnt_in,
                                               h264au_pkg::byte_item(h264au_pkg::ByteOne));
               cnt_in  = h264au_pkg::bump_count(cnt_in);
               list_in = h264au_pkg::push_item(list_in, cnt_in, h264au_pkg::byte_item(b));
               cnt_in  = h264au_pkg::bump_count(cnt_in);
               phase_in = h264au_pkg::PhCopy;
            end
         end
      end else begin
         if (b == h264au_pkg::ByteZero) begin
            if (held_in < h264au_pkg::MaxHeld) begin
               held_in = held_in + 2'd1;
            end else if (phase_in == h264au_pkg::PhCopy) begin
               list_in = h264au_pkg::push_item(list_in, cnt_in,
                                               h264au_pkg::byte_item(h264au_pkg::ByteZero));
               cnt_in  = h264au_pkg::bump_count(cnt_in);
            end
         end else if (b == h264au_pkg::ByteOne && held_in >= 2'd2) begin
            phase_in = h264au_pkg::PhHeader;
            held_in  = 2'd0;
         end else begin
            if (phase_in == h264au_pkg::PhCopy) begin
               for (int i = 0; i < 3; i++) begin
                  if (2'(i) < held_in) begin
                     list_in = h264au_pkg::push_item(list_in, cnt_in,
                                                     h264au_pkg::byte_item(h264au_pkg::ByteZero));
                     cnt_in  = h264au_pkg::bump_count(cnt_in);
                  end
               end
               list_in = h264au_pkg::push_item(list_in, cnt_in, h264au_pkg::byte_item(b));
               cnt_in  = h264au_pkg::bump_count(cnt_in);
            end
            held_in = 2'd0;
         end
      end

      // end of buffer
      if (req_payload.buffer_last) begin
         if (phase_in == h264au_pkg::PhCopy) begin
            for (int i = 0; i < 3; i++) begin
               if (2'(i) < held_in) begin
                  list_in = h264au_pkg::push_item(list_in, cnt_in,
                                                  h264au_pkg::byte_item(h264au_pkg::ByteZero));
                  cnt_in  = h264au_pkg::bump_count(cnt_in);
               end
            end
         end
         if (cnt_in < CW'(h264au_pkg::MaxItems)) begin
            if (gp_in || gs_in) begin
               list_in = h264au_pkg::push_item(list_in, cnt_in,
                                               h264au_pkg::marker_item(gs_in, gi_in));
               cnt_in  = h264au_pkg::bump_count(cnt_in);
            end
            gp_in = 1'b0;
            gs_in = 1'b0;
            gi_in = 1'b0;
         end
         phase_in = h264au_pkg::PhSeek;
         held_in  = 2'd0;
      end

      if (cnt_in != '0) begin
         list_in[$clog2(h264au_pkg::MaxItems)'(cnt_in - CW'(1))].run_last = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= h264au_pkg::PhSeek;
         held_ff  <= 2'd0;
         gp_ff    <= 1'b0;
         gs_ff    <= 1'b0;
         gi_ff    <= 1'b0;
         cnt_ff   <= '0;
         rd_ff    <= '0;
      end else if (req_take) begin
         phase_ff <= phase_in;
         held_ff  <= held_in;
         gp_ff    <= gp_in;
         gs_ff    <= gs_in;
         gi_ff    <= gi_in;
         cnt_ff   <= cnt_in;
         rd_ff    <= '0;
      end else if (rsp_take) begin
         rd_ff <= rd_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         list_ff <= list_in;
      end
   end

endmodule

// ----- verif/annexb_group_checker.sv -----
// ----------------------------------------------------------------------------
// annexb_group_checker
// tracks the start code parser and group flags of the splitter for every
// accepted request, queues the reframed byte and marker items that it must
// produce, and compares each accepted result item against the oldest one
// ----------------------------------------------------------------------------
module annexb_group_checker (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_stall,
   input  h264au_pkg::req_type req_payload,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  h264au_pkg::rsp_type rsp_payload,
   output int                  mismatch_total,
   output int                  items_owed,
   output int                  items_seen,
   output int                  markers_seen
);

   h264au_pkg::phase_type parse_phase;
   logic [1:0]            held_zeros;
   logic                  has_params;
   logic                  has_slice;
   logic                  has_idr;
   h264au_pkg::rsp_type   run_items [h264au_pkg::MaxItems];
   int                    run_count;
   h264au_pkg::rsp_type   reframed_q [$];
   int                    mismatches;
   int                    seen_count;
   int                    marker_count;

   task automatic add_item(input h264au_pkg::rsp_type it);
      if (run_count < h264au_pkg::MaxItems) begin
         run_items[run_count] = it;
         run_count++;
      end
   endtask

   task automatic add_byte(input logic [7:0] value);
      h264au_pkg::rsp_type it;
      it = '0;
      it.out_byte = value;
      add_item(it);
   endtask

   task automatic close_group();
      h264au_pkg::rsp_type it;
      if (has_params || has_slice) begin
         it = '0;
         it.group_end = 1'b1;
         it.group_kind = has_idr ? h264au_pkg::KindIdr :
                         (has_slice ? h264au_pkg::KindSlice : h264au_pkg::KindParams);
         add_item(it);
      end
      has_params = 1'b0;
      has_slice = 1'b0;
      has_idr = 1'b0;
   endtask

   task automatic predict_reframe(input h264au_pkg::req_type r);
      logic [7:0] b;
      logic [7:0] masked;
      logic [4:0] nal_type;
      logic       copying;
      int         k;
      b = r.data_byte;
      run_count = 0;

      // marker owed from a buffer that ended on a full run
      if (parse_phase == h264au_pkg::PhSeek)
         close_group();

      if (parse_phase == h264au_pkg::PhHeader) begin
         if (b == h264au_pkg::ByteZero) begin
            if (held_zeros < h264au_pkg::MaxHeld) begin
               held_zeros++;
            end else begin
               close_group();
               parse_phase = h264au_pkg::PhDrop;
            end
         end else if (b == h264au_pkg::ByteOne && held_zeros >= 2'd2) begin
            held_zeros = '0;
         end else if (held_zeros >= 2'd1) begin
            close_group();
            parse_phase = h264au_pkg::PhDrop;
            held_zeros = '0;
         end else begin
            masked = b & h264au_pkg::TypeMask;
            nal_type = masked[4:0];
            if (nal_type == h264au_pkg::TypeSps || nal_type == h264au_pkg::TypePps) begin
               if (has_slice)
                  close_group();
               has_params = 1'b1;
               parse_phase = h264au_pkg::PhCopy;
            end else if (nal_type >= h264au_pkg::TypeSliceLow &&
                         nal_type <= h264au_pkg::TypeSliceIdr) begin
               has_slice = 1'b1;
               if (nal_type == h264au_pkg::TypeSliceIdr)
                  has_idr = 1'b1;
               parse_phase = h264au_pkg::PhCopy;
            end else begin
               close_group();
               parse_phase = h264au_pkg::PhDrop;
            end
            if (parse_phase == h264au_pkg::PhCopy) begin
               add_byte(h264au_pkg::ByteZero);
               add_byte(h264au_pkg::ByteZero);
               add_byte(h264au_pkg::ByteZero);
               add_byte(h264au_pkg::ByteOne);
               add_byte(b);
            end
         end
      end else begin
         copying = (parse_phase == h264au_pkg::PhCopy);
         if (b == h264au_pkg::ByteZero) begin
            if (held_zeros < h264au_pkg::MaxHeld)
               held_zeros++;
            else if (copying)
               add_byte(h264au_pkg::ByteZero);
         end else if (b == h264au_pkg::ByteOne && held_zeros >= 2'd2) begin
            parse_phase = h264au_pkg::PhHeader;
            held_zeros = '0;
         end else begin
            if (copying) begin
               for (k = 0; k < held_zeros; k++)
                  add_byte(h264au_pkg::ByteZero);
               add_byte(b);
            end
            held_zeros = '0;
         end
      end

      if (r.buffer_last) begin
         if (parse_phase == h264au_pkg::PhCopy)
            for (k = 0; k < held_zeros; k++)
               add_byte(h264au_pkg::ByteZero);
         if (run_count < h264au_pkg::MaxItems)
            close_group();
         parse_phase = h264au_pkg::PhSeek;
         held_zeros = '0;
      end

      if (run_count > 0)
         run_items[run_count - 1].run_last = 1'b1;
      for (k = 0; k < run_count; k++)
         reframed_q.insert(reframed_q.size(), run_items[k]);
   endtask

   always @(posedge clock) begin
      h264au_pkg::rsp_type want;
      if (reset) begin
         parse_phase = h264au_pkg::PhSeek;
         held_zeros = '0;
         has_params = 1'b0;
         has_slice = 1'b0;
         has_idr = 1'b0;
         reframed_q.delete();
      end else begin
         if (req_valid && !req_stall)
            predict_reframe(req_payload);
         if (rsp_valid && !rsp_stall) begin
            seen_count++;
            if (rsp_payload.group_end)
               marker_count++;
            if (reframed_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result: byte %02h end %0b kind %0d last %0b",
                     rsp_payload.out_byte, rsp_payload.group_end,
                     rsp_payload.group_kind, rsp_payload.run_last);
            end else begin
               want = reframed_q.pop_front();
               if (rsp_payload.out_byte !== want.out_byte ||
                   rsp_payload.group_end !== want.group_end ||
                   rsp_payload.group_kind !== want.group_kind ||
                   rsp_payload.run_last !== want.run_last) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"mismatch: expected byte %02h end %0b kind %0d last %0b,",
                        " got byte %02h end %0b kind %0d last %0b"},
                        want.out_byte, want.group_end, want.group_kind, want.run_last,
                        rsp_payload.out_byte, rsp_payload.group_end,
                        rsp_payload.group_kind, rsp_payload.run_last);
               end
            end
         end
      end
      mismatch_total <= mismatches;
      items_owed <= reframed_q.size();
      items_seen <= seen_count;
      markers_seen <= marker_count;
   end

endmodule

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// drives annex b byte buffers into the access unit splitter: a short directed
// set of start code corner cases, then random buffers of well formed units
// with random content mixed with noise, under bursty requests and a
// patterned result stall; the checker predicts and compares every item
// ----------------------------------------------------------------------------
module tb;

   localparam int RandomRequests = 210;
   localparam int CycleLimit = 100000;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   h264au_pkg::req_type req_payload = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   h264au_pkg::rsp_type rsp_payload;

   int         mismatch_total;
   int         items_owed;
   int         items_seen;
   int         markers_seen;
   int         cycle_count = 0;
   logic [8:0] stall_tick = '0;
   int         burst_left = 0;
   int         requests_sent = 0;
   int         buffers_sent = 0;
   logic [7:0] stream_q [$];

   always #10 clock = ~clock;

   h264_annexb_access_unit_splitter dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   annexb_group_checker group_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_payload    (req_payload),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_payload    (rsp_payload),
      .mismatch_total (mismatch_total),
      .items_owed     (items_owed),
      .items_seen     (items_seen),
      .markers_seen   (markers_seen)
   );

   // result stall pattern: free, random, mostly stalled, rare
   always @(posedge clock) begin
      stall_tick <= stall_tick + 9'd1;
      case (stall_tick[8:7])
         2'd0: rsp_stall <= 1'b0;
         2'd1: rsp_stall <= 1'($urandom_range(0, 1));
         2'd2: rsp_stall <= (stall_tick[1:0] != 2'd0);
         default: rsp_stall <= ($urandom_range(0, 7) == 0);
      endcase
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   function automatic logic [7:0] stream_byte();
      int pick;
      pick = $urandom_range(0, 19);
      if (pick < 7)
         return h264au_pkg::ByteZero;
      if (pick < 9)
         return h264au_pkg::ByteOne;
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic append_byte(input logic [7:0] value);
      stream_q.insert(stream_q.size(), value);
   endtask

   task automatic send_stream();
      int                  gap;
      h264au_pkg::req_type next_req;
      foreach (stream_q[i]) begin
         if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
            burst_left = $urandom_range(1, 16);
         end
         burst_left--;
         next_req.data_byte = stream_q[i];
         next_req.buffer_last = (i == stream_q.size() - 1);
         req_valid <= 1'b1;
         req_payload <= next_req;
         @(posedge clock);
         while (req_stall) @(posedge clock);
         requests_sent++;
      end
      buffers_sent++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (items_owed != 0);
   endtask

   initial begin
      int         directed_total;
      int         unit_shape;
      logic [4:0] nal_type;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // junk before the first start code, sps and pps kept together, idr,
      // four zeros inside a unit, sps after slices ending the buffer
      stream_q = '{8'hAB, 8'h00, 8'h00, 8'h01, 8'h67, 8'h42, 8'h00, 8'h00, 8'h01,
                   8'h68, 8'hCE, 8'h00, 8'h00, 8'h00, 8'h01, 8'h65, 8'h00, 8'h00,
                   8'h00, 8'h00, 8'h88, 8'h00, 8'h00, 8'h01, 8'h67};
      send_stream();
      // empty unit, zero header byte, buffer ending before a header
      stream_q = '{8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h01, 8'h41, 8'h00, 8'h00,
                   8'h01, 8'h00, 8'h7F, 8'h00, 8'h00, 8'h00, 8'h01};
      send_stream();
      // single byte buffer with nothing to close
      stream_q = '{8'hFF};
      send_stream();
      wait_drained();

      directed_total = requests_sent;
      while (requests_sent - directed_total < RandomRequests) begin
         stream_q.delete();
         if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 10)) append_byte(stream_byte());
         end else begin
            if ($urandom_range(0, 3) == 0)
               repeat ($urandom_range(1, 3)) append_byte(stream_byte());
            repeat ($urandom_range(1, 5)) begin
               if ($urandom_range(0, 1))
                  append_byte(h264au_pkg::ByteZero);
               append_byte(h264au_pkg::ByteZero);
               append_byte(h264au_pkg::ByteZero);
               append_byte(h264au_pkg::ByteOne);
               unit_shape = $urandom_range(0, 9);
               if (unit_shape != 0) begin
                  if (unit_shape == 1) begin
                     append_byte(h264au_pkg::ByteZero);
                  end else begin
                     case ($urandom_range(0, 7))
                        0: nal_type = h264au_pkg::TypeSps;
                        1: nal_type = h264au_pkg::TypePps;
                        2, 3: nal_type = 5'($urandom_range(h264au_pkg::TypeSliceLow,
                                                          h264au_pkg::TypeSliceIdr - 5'd1));
                        4: nal_type = h264au_pkg::TypeSliceIdr;
                        default: nal_type = 5'($urandom_range(0, 31));
                     endcase
                     append_byte({3'($urandom_range(0, 7)), nal_type});
                  end
                  repeat ($urandom_range(0, 8)) append_byte(stream_byte());
               end
            end
         end
         send_stream();
         if ($urandom_range(0, 7) == 0)
            wait_drained();
      end

      wait_drained();
      repeat (8) @(posedge clock);
      $display("covered %0d requests in %0d buffers, %0d result items with %0d group markers",
         requests_sent, buffers_sent, items_seen, markers_seen);
      if (mismatch_total == 0 && items_owed == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/core/h264au_pkg.sv
rtl/core/h264_annexb_access_unit_splitter.sv
verif/annexb_group_checker.sv
verif/tb.sv
